@@ src/cmgv_pkg.sv @@
package cmgv_pkg;

  localparam int unsigned COUNT_BITS_DEF = 32;
  localparam int unsigned QUEUE_DEPTH    = 2;
  localparam int unsigned PHASE_COUNT    = 8;

  localparam logic [2:0] MODE_GB18030  = 3'd0;
  localparam logic [2:0] MODE_BIG5     = 3'd1;
  localparam logic [2:0] MODE_SJIS     = 3'd2;
  localparam logic [2:0] MODE_EUCJP    = 3'd3;
  localparam logic [2:0] MODE_EUCKR    = 3'd4;
  localparam logic [2:0] MODE_UNKNOWN  = 3'd5;

  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_TRAIL  = 3'd1;
  localparam logic [2:0] PH_GB3    = 3'd2;
  localparam logic [2:0] PH_GB4    = 3'd3;
  localparam logic [2:0] PH_SS2    = 3'd4;
  localparam logic [2:0] PH_SS3A   = 3'd5;
  localparam logic [2:0] PH_SS3B   = 3'd6;
  localparam logic [2:0] PH_BAD    = 3'd7;

  localparam logic [1:0] VERDICT_COMPLETE   = 2'd0;
  localparam logic [1:0] VERDICT_INCOMPLETE = 2'd1;
  localparam logic [1:0] VERDICT_INVALID    = 2'd2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       end_of_buffer;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  verdict;
    logic [31:0] prefix_bytes;
  } out_item_t;

  // next phase for every possible current phase
  typedef struct packed {
    logic [PHASE_COUNT-1:0][2:0] next_phase;
    logic                        has_byte;
    logic                        end_of_buffer;
  } cls_t;

endpackage

@@ src/cjk_multibyte_grammar_validator.sv @@
// Validates a byte stream against the grammar of the CJK encoding selected by
// the mode register (GB18030, Big5, Shift-JIS, EUC-JP, EUC-KR, or ASCII only),
// one byte per cycle. Items flow with no gaps: each accepted item is classified
// on its way in, waits in a two-entry queue and is applied to the character
// state when it is popped from the queue; the result for the item that ends a
// buffer is captured in the output register at that same pop. The output
// register frees the input side; the input stalls only once the queue has filled
// behind a stalled result. Write the mode only while no buffer is in flight.
module cjk_multibyte_grammar_validator
  import cmgv_pkg::*;
#(
  parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [2:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  in_item_t   in_item_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output out_item_t  out_item_o
);

  cls_t cls_in;
  cls_t cls_out;
  logic q_full;
  logic q_valid;
  logic q_pop;

  assign in_stall_o = q_full;

  cmgv_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .in_item_i  (in_item_i),
    .cls_o      (cls_in)
  );

  cmgv_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_valid_i),
    .push_data_i (cls_in),
    .full_o      (q_full),
    .valid_o     (q_valid),
    .pop_i       (q_pop),
    .pop_data_o  (cls_out)
  );

  cmgv_back #(
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (q_valid),
    .cls_i       (cls_out),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

@@ src/cmgv_front.sv @@
module cmgv_front
  import cmgv_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     cfg_we_i,
  input  logic [2:0] cfg_data_i,
  input  in_item_t in_item_i,
  output cls_t     cls_o
);

  logic [2:0] mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_GB18030;
    end else if (cfg_we_i) begin
      mode_q <= cfg_data_i;
    end
  end

  function automatic logic in_rng(logic [7:0] b, logic [7:0] lo, logic [7:0] hi);
    return (b >= lo) && (b <= hi);
  endfunction

  logic [7:0] b;
  logic [2:0] lead_ph;
  logic [2:0] second_ph;

  assign b = in_item_i.data_byte;

  always_comb begin
    case (mode_q)
      MODE_GB18030, MODE_BIG5: begin
        lead_ph = in_rng(b, 8'h81, 8'hfe) ? PH_TRAIL : PH_BAD;
      end
      MODE_SJIS: begin
        if (in_rng(b, 8'ha1, 8'hdf)) begin
          lead_ph = PH_IDLE;
        end else if (in_rng(b, 8'h81, 8'h9f) || in_rng(b, 8'he0, 8'hfc)) begin
          lead_ph = PH_TRAIL;
        end else begin
          lead_ph = PH_BAD;
        end
      end
      MODE_EUCJP: begin
        if (b == 8'h8e) begin
          lead_ph = PH_SS2;
        end else if (b == 8'h8f) begin
          lead_ph = PH_SS3A;
        end else begin
          lead_ph = in_rng(b, 8'ha1, 8'hfe) ? PH_TRAIL : PH_BAD;
        end
      end
      MODE_EUCKR: begin
        lead_ph = in_rng(b, 8'ha1, 8'hfe) ? PH_TRAIL : PH_BAD;
      end
      default: begin
        lead_ph = PH_BAD;
      end
    endcase
  end

  always_comb begin
    case (mode_q)
      MODE_GB18030: begin
        if (in_rng(b, 8'h30, 8'h39)) begin
          second_ph = PH_GB3;
        end else begin
          second_ph = (in_rng(b, 8'h40, 8'hfe) && b != 8'h7f) ? PH_IDLE : PH_BAD;
        end
      end
      MODE_BIG5: begin
        second_ph = (in_rng(b, 8'h40, 8'h7e) || in_rng(b, 8'ha1, 8'hfe)) ? PH_IDLE : PH_BAD;
      end
      MODE_SJIS: begin
        second_ph = (in_rng(b, 8'h40, 8'h7e) || in_rng(b, 8'h80, 8'hfc)) ? PH_IDLE : PH_BAD;
      end
      MODE_EUCJP, MODE_EUCKR: begin
        second_ph = in_rng(b, 8'ha1, 8'hfe) ? PH_IDLE : PH_BAD;
      end
      default: begin
        second_ph = PH_BAD;
      end
    endcase
  end

  always_comb begin
    cls_o.has_byte               = in_item_i.has_byte;
    cls_o.end_of_buffer          = in_item_i.end_of_buffer;
    cls_o.next_phase[PH_IDLE]    = (b <= 8'h7f) ? PH_IDLE : lead_ph;
    cls_o.next_phase[PH_TRAIL]   = second_ph;
    cls_o.next_phase[PH_GB3]     = in_rng(b, 8'h81, 8'hfe) ? PH_GB4 : PH_BAD;
    cls_o.next_phase[PH_GB4]     = in_rng(b, 8'h30, 8'h39) ? PH_IDLE : PH_BAD;
    cls_o.next_phase[PH_SS2]     = in_rng(b, 8'ha1, 8'hdf) ? PH_IDLE : PH_BAD;
    cls_o.next_phase[PH_SS3A]    = in_rng(b, 8'ha1, 8'hfe) ? PH_SS3B : PH_BAD;
    cls_o.next_phase[PH_SS3B]    = in_rng(b, 8'ha1, 8'hfe) ? PH_IDLE : PH_BAD;
    cls_o.next_phase[PH_BAD]     = PH_BAD;
  end

endmodule

@@ src/cmgv_queue.sv @@
module cmgv_queue
  import cmgv_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cls_t push_data_i,
  output logic full_o,
  output logic valid_o,
  input  logic pop_i,
  output cls_t pop_data_o
);

  localparam int unsigned PtrBits = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntBits = $clog2(QUEUE_DEPTH + 1);

  cls_t               mem_q [QUEUE_DEPTH];
  logic [PtrBits-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrBits-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntBits-1:0] cnt_q, cnt_d;
  logic               do_push;
  logic               do_pop;

  assign full_o     = (cnt_q == CntBits'(QUEUE_DEPTH));
  assign valid_o    = (cnt_q != '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrBits'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrBits'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

@@ src/cmgv_back.sv @@
module cmgv_back
  import cmgv_pkg::*;
#(
  parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      valid_i,
  input  cls_t      cls_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  logic [COUNT_BITS-1:0] byte_count_q, byte_count_d;
  logic [COUNT_BITS-1:0] char_start_q, char_start_d;
  logic [2:0]            phase_q, phase_d;
  logic                  err_q, err_d;
  logic                  out_valid_q, out_valid_d;
  out_item_t             out_item_q, out_item_d;
  logic [2:0]            np;
  logic [COUNT_BITS-1:0] len;
  logic [63:0]           len_ext;
  logic [1:0]            verdict;

  assign pop_o       = valid_i && !(out_valid_q && out_stall_i);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;
  assign np          = cls_i.next_phase[phase_q];

  always_comb begin
    byte_count_d = byte_count_q;
    char_start_d = char_start_q;
    phase_d      = phase_q;
    err_d        = err_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_item_d   = out_item_q;
    verdict      = VERDICT_COMPLETE;
    len          = '0;
    len_ext      = '0;
    if (pop_o) begin
      if (cls_i.has_byte && !err_q) begin
        if (byte_count_q != '1) begin
          byte_count_d = byte_count_q + 1'b1;
        end
        if (phase_q == PH_IDLE) begin
          char_start_d = byte_count_q;
        end
        if (np == PH_BAD) begin
          err_d   = 1'b1;
          phase_d = PH_IDLE;
        end else begin
          phase_d = np;
        end
      end
      if (err_d) begin
        verdict = VERDICT_INVALID;
        len     = char_start_d;
      end else if (phase_d != PH_IDLE) begin
        verdict = VERDICT_INCOMPLETE;
        len     = char_start_d;
      end else begin
        verdict = VERDICT_COMPLETE;
        len     = byte_count_d;
      end
      len_ext = 64'(len);
      if (cls_i.end_of_buffer) begin
        out_valid_d             = 1'b1;
        out_item_d.verdict      = verdict;
        out_item_d.prefix_bytes = (|len_ext[63:32]) ? 32'hffff_ffff : len_ext[31:0];
        byte_count_d            = '0;
        char_start_d            = '0;
        phase_d                 = PH_IDLE;
        err_d                   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_count_q <= '0;
      char_start_q <= '0;
      phase_q      <= PH_IDLE;
      err_q        <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      byte_count_q <= byte_count_d;
      char_start_q <= char_start_d;
      phase_q      <= phase_d;
      err_q        <= err_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_item_q <= out_item_d;
  end

endmodule

@@ src/cmgv_checker.sv @@
module cmgv_checker
  import cmgv_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_item_o
);

  // result held while stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // stalled result payload does not change
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_item_o))
    else $error("result changed while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.verdict == VERDICT_COMPLETE ||
                     out_item_o.verdict == VERDICT_INCOMPLETE ||
                     out_item_o.verdict == VERDICT_INVALID))
    else $error("illegal verdict code");

  // queue can only fill up behind a blocked result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(out_valid_o && out_stall_i))
    else $error("input stalled without output back-pressure");

endmodule

bind cjk_multibyte_grammar_validator cmgv_checker u_cmgv_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);
